FILE: rtl/core/itdt_pkg.sv
package itdt_pkg;

   // ascii codes of the emitted characters, 6 bits wide
   localparam logic [5:0] CH_SPACE = 6'd32;
   localparam logic [5:0] CH_PLUS  = 6'd43;
   localparam logic [5:0] CH_MINUS = 6'd45;
   localparam logic [5:0] CH_ZERO  = 6'd48;

   // a 32-bit magnitude has at most ten decimal digits
   localparam int DIGIT_COUNT = 10;
   localparam int DIGIT_IDX_W = 4;

   // x / 10 == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   // classified number passed from the front to the back
   typedef struct packed {
      logic [31:0] mag;
      logic [5:0]  width;
      logic        has_sign;
      logic [5:0]  sign_char;
   } itdt_entry_type;

endpackage

FILE: rtl/core/itdt_if.sv
interface itdt_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] number;
   logic [5:0]         min_digits;
   logic               always_sign;

   modport source (output valid, output number, output min_digits, output always_sign,
                   input ready);
   modport sink (input valid, input number, input min_digits, input always_sign,
                 output ready);
endinterface

interface itdt_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink (input valid, input character, input last, output ready);
endinterface

FILE: rtl/core/itdt_front.sv
module itdt_front #(
   parameter int MAX_MIN_DIGITS = 32
) (
   itdt_req_if.sink               req_ch,
   output logic                   push_valid,
   input  logic                   push_ready,
   output itdt_pkg::itdt_entry_type push_entry
);

   logic        neg;
   logic [5:0]  clamped;

   // handshake passes straight through to the queue
   assign push_valid  = req_ch.valid;
   assign req_ch.ready = push_ready;

   // sign and magnitude; the most negative value wraps to 2^31 unsigned
   assign neg = req_ch.number[31];
   assign push_entry.mag = neg ? (32'd0 - 32'(req_ch.number)) : 32'(req_ch.number);

   // digit field width: clamp to the limit, zero means one
   assign clamped = (req_ch.min_digits > 6'(MAX_MIN_DIGITS)) ? 6'(MAX_MIN_DIGITS)
                                                              : req_ch.min_digits;
   assign push_entry.width = (clamped == 6'd0) ? 6'd1 : clamped;

   // sign character: minus, plus, space for zero, or none
   assign push_entry.has_sign  = neg | req_ch.always_sign;
   assign push_entry.sign_char = neg ? itdt_pkg::CH_MINUS
                               : ((req_ch.number == 32'sd0) ? itdt_pkg::CH_SPACE
                                                            : itdt_pkg::CH_PLUS);

endmodule

FILE: rtl/core/itdt_queue.sv
module itdt_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  itdt_pkg::itdt_entry_type push_entry,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output itdt_pkg::itdt_entry_type pop_entry
);

   itdt_pkg::itdt_entry_type entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/core/itdt_back.sv
module itdt_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  itdt_pkg::itdt_entry_type pop_entry,
   itdt_rsp_if.source               rsp_ch
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_SPLIT = 6'b000100,
      ST_PAD   = 6'b001000,
      ST_SIGN  = 6'b010000,
      ST_DIGIT = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] mag_ff, mag_in;
   logic [63:0] prod_ff, prod_in;
   logic [5:0]  width_ff, width_in;
   logic        has_sign_ff, has_sign_in;
   logic [5:0]  sign_char_ff, sign_char_in;
   logic [itdt_pkg::DIGIT_IDX_W-1:0] ndig_ff, ndig_in;
   logic [5:0]  pad_ff, pad_in;
   logic        valid_ff, valid_in;
   logic [5:0]  char_ff, char_in;
   logic        last_ff, last_in;
   logic [3:0]  digits_ff [itdt_pkg::DIGIT_COUNT];

   logic [31:0] quot;
   logic [3:0]  rem;
   logic [3:0]  cur_digit;
   logic [itdt_pkg::DIGIT_IDX_W-1:0] ndig_next;
   logic        out_free;
   logic        dig_we;

   assign rsp_ch.valid     = valid_ff;
   assign rsp_ch.character = char_ff;
   assign rsp_ch.last      = last_ff;

   // output register can take a new beat when empty or being drained
   assign out_free = ~valid_ff | rsp_ch.ready;

   // quotient and remainder of the current magnitude by ten
   assign quot      = {3'b000, prod_ff[63:itdt_pkg::RECIP_SHIFT]};
   assign rem       = mag_ff[3:0] - ({quot[0], 3'b000} + {quot[2:0], 1'b0});
   assign ndig_next = ndig_ff + 1'b1;
   assign cur_digit = digits_ff[ndig_ff - 1'b1];

   // sequencer: split into digits, then pad, sign and digits out
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      width_in     = width_ff;
      has_sign_in  = has_sign_ff;
      sign_char_in = sign_char_ff;
      ndig_in      = ndig_ff;
      pad_in       = pad_ff;
      valid_in     = valid_ff & ~rsp_ch.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      pop_ready    = 1'b0;
      dig_we       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               mag_in       = pop_entry.mag;
               width_in     = pop_entry.width;
               has_sign_in  = pop_entry.has_sign;
               sign_char_in = pop_entry.sign_char;
               ndig_in      = '0;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = 64'(mag_ff) * 64'(itdt_pkg::RECIP_TEN);
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            dig_we  = 1'b1;
            ndig_in = ndig_next;
            mag_in  = quot;
            if (quot == 32'd0) begin
               pad_in   = (width_ff > 6'(ndig_next)) ? (width_ff - 6'(ndig_next)) : 6'd0;
               state_in = ST_PAD;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_PAD: begin
            if (pad_ff == 6'd0) begin
               state_in = ST_SIGN;
            end else if (out_free) begin
               valid_in = 1'b1;
               char_in  = itdt_pkg::CH_SPACE;
               last_in  = 1'b0;
               pad_in   = pad_ff - 6'd1;
            end
         end
         ST_SIGN: begin
            if (!has_sign_ff) begin
               state_in = ST_DIGIT;
            end else if (out_free) begin
               valid_in = 1'b1;
               char_in  = sign_char_ff;
               last_in  = 1'b0;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               valid_in = 1'b1;
               char_in  = itdt_pkg::CH_ZERO + {2'b00, cur_digit};
               last_in  = (ndig_ff == 4'd1);
               ndig_in  = ndig_ff - 1'b1;
               if (ndig_ff == 4'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         ndig_ff  <= '0;
         pad_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         ndig_ff  <= ndig_in;
         pad_ff   <= pad_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      prod_ff      <= prod_in;
      width_ff     <= width_in;
      has_sign_ff  <= has_sign_in;
      sign_char_ff <= sign_char_in;
      char_ff      <= char_in;
      last_ff      <= last_in;
   end

   // digit store, least significant digit first
   always_ff @(posedge clock) begin
      if (dig_we) begin
         digits_ff[ndig_ff] <= rem;
      end
   end

endmodule

FILE: rtl/core/int_to_decimal_text_top.sv
// Signed 32-bit integer to decimal text. Each req beat carries a number, a minimum
// digit count (clamped to MAX_MIN_DIGITS, zero means one) and an always-sign flag;
// the rsp channel returns the ASCII text one character per beat, most significant
// first, with last set on the final character. Leading spaces pad the digits to the
// minimum count and come before the sign; '-' marks negatives, and with always-sign
// a '+' (or a space for zero) is written for non-negatives. A front stage classifies
// the number into a two-entry queue, so a new number is taken while the back is
// still busy. The back splits the magnitude into digits by a reciprocal multiply, a
// multiply state and a split state for each digit, then sends the characters at most
// one per cycle while the rsp channel is ready. It takes the next number from the
// queue only once the final character is in its output register; the divide-by-ten
// unit is shared by all digits and a single output register holds each character.
module int_to_decimal_text_top #(
   parameter int MAX_MIN_DIGITS = 32
) (
   input logic        clock,
   input logic        reset,
   itdt_req_if.sink   req_ch,
   itdt_rsp_if.source rsp_ch
);

   logic                     push_valid;
   logic                     push_ready;
   itdt_pkg::itdt_entry_type push_entry;
   logic                     pop_valid;
   logic                     pop_ready;
   itdt_pkg::itdt_entry_type pop_entry;

   // classify incoming numbers
   itdt_front #(
      .MAX_MIN_DIGITS (MAX_MIN_DIGITS)
   ) u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // decouple front and back
   itdt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // digit split and character output
   itdt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_ch    (rsp_ch)
   );

endmodule
